/* design/loop_clip_player_crossfade_top_macros.svh */
// ----------------------------------------------------------------------------
// loop clip player assertion macros
// shared concurrent assertion forms for the clip player checker
// ----------------------------------------------------------------------------
`ifndef LOOP_CLIP_PLAYER_CROSSFADE_TOP_MACROS_SVH
`define LOOP_CLIP_PLAYER_CROSSFADE_TOP_MACROS_SVH

// same-cycle implication
`define LCP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCP_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lcp_pkg.sv */
// ----------------------------------------------------------------------------
// lcp_pkg
// codes, widths and defaults shared by the clip player files
// ----------------------------------------------------------------------------
package lcp_pkg;

    localparam int CLIP_DEPTH_DEF      = 65536;
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int MAX_FADE_DEF        = 16384;
    localparam int GAIN_TABLE_SIZE_DEF = 1024;

    localparam int KIND_W     = 2;
    localparam int ADDR_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int FRAMES_W   = 17;
    localparam int RSTART_W   = 16;
    localparam int NFADE_W    = 15;
    localparam int GAIN_W     = 16;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_FRAMES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_FADE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO_BUS     = 3'd5;

    localparam logic [NFADE_W-1:0] NOMINAL_FADE_RST = 15'd384;

    // quarter-sine odd polynomial, q30
    localparam longint unsigned SIN_A1 = 64'd1686629713;
    localparam longint unsigned SIN_A3 = 64'd693598680;
    localparam longint unsigned SIN_A5 = 64'd85569300;
    localparam longint unsigned SIN_A7 = 64'd5027000;
    localparam longint unsigned SIN_A9 = 64'd172270;
    localparam longint unsigned GAIN_CAP = 64'd32767;

endpackage

/* design/lcp_req_if.sv */
// ----------------------------------------------------------------------------
// lcp_req_if
// request channel: load, start, stop and tick items
// ----------------------------------------------------------------------------
interface lcp_req_if
    import lcp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic        [KIND_W-1:0]      kind;
    logic        [ADDR_W-1:0]      clip_address;
    logic signed [SAMPLE_BITS-1:0] clip_left;
    logic signed [SAMPLE_BITS-1:0] clip_right;
    logic signed [SAMPLE_BITS-1:0] bus_left;
    logic signed [SAMPLE_BITS-1:0] bus_right;

    modport source (output valid, kind, clip_address, clip_left, clip_right, bus_left,
                    bus_right, input ready);
    modport sink   (input valid, kind, clip_address, clip_left, clip_right, bus_left,
                    bus_right, output ready);
endinterface

/* design/lcp_rsp_if.sv */
// ----------------------------------------------------------------------------
// lcp_rsp_if
// response channel: mixed bus frame and playback status
// ----------------------------------------------------------------------------
interface lcp_rsp_if
    import lcp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          playing;
    logic                          finished;

    modport source (output valid, out_left, out_right, playing, finished, input ready);
    modport sink   (input valid, out_left, out_right, playing, finished, output ready);
endinterface

/* design/lcp_cfg_if.sv */
// ----------------------------------------------------------------------------
// lcp_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface lcp_cfg_if
    import lcp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/loop_clip_player_crossfade_top.sv */
// ----------------------------------------------------------------------------
// loop_clip_player_crossfade_top
// stereo clip player mixing stored clip frames into a live bus, with
// equal-power crossfade at loop wraps
// ----------------------------------------------------------------------------
// load, start, stop: resolve, fade, decode and output states; a plain tick adds
// read and mix states, a crossfade tick adds divider, gain and multiply states
// one request at a time: a request is taken only in the idle state; the gain index
// divider is bit-serial and the clip memories have a single read port
// reset clears configuration, playback and output registers; clip memory is undefined until loaded
// ----------------------------------------------------------------------------
module loop_clip_player_crossfade_top
    import lcp_pkg::*;
#(
    parameter int CLIP_DEPTH      = CLIP_DEPTH_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int MAX_FADE        = MAX_FADE_DEF,
    parameter int GAIN_TABLE_SIZE = GAIN_TABLE_SIZE_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    lcp_req_if.sink   req,
    lcp_rsp_if.source rsp,
    lcp_cfg_if.sink   cfg
);

    localparam int SB   = SAMPLE_BITS;
    localparam int AW   = $clog2(CLIP_DEPTH);
    localparam int TW   = $clog2(CLIP_DEPTH + 1);
    localparam int CW   = (TW > FRAMES_W) ? TW : FRAMES_W;
    localparam int FW   = $clog2(MAX_FADE + 1);
    localparam int ADW  = CW + 1;
    localparam int QB   = $clog2(GAIN_TABLE_SIZE + 1);
    localparam int KW   = $clog2(QB + 1);
    localparam longint NUM_MAX = (2 * longint'(MAX_FADE) + 1) * GAIN_TABLE_SIZE + MAX_FADE;
    localparam int NW   = $clog2(NUM_MAX + 1);
    localparam int DW   = FW + 1 + QB;
    localparam int RW   = (NW > DW) ? NW : DW;
    localparam int PW   = SB + GAIN_W + 1;
    localparam int CLW  = SB + 1;
    localparam int MW   = SB + 3;

    typedef logic [GAIN_W-1:0] gain_rom_t [0:GAIN_TABLE_SIZE];

    function automatic gain_rom_t build_gain_rom();
        gain_rom_t rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p;
        longint unsigned g;
        for (int k = 0; k <= GAIN_TABLE_SIZE; k++)
        begin
            x  = (longint'(k) << 30) / GAIN_TABLE_SIZE;
            x2 = (x * x) >> 30;
            p  = SIN_A9;
            p  = SIN_A7 - ((x2 * p) >> 30);
            p  = SIN_A5 - ((x2 * p) >> 30);
            p  = SIN_A3 - ((x2 * p) >> 30);
            p  = SIN_A1 - ((x2 * p) >> 30);
            g  = (((x * p) >> 30) + 64'd16384) >> 15;
            rom[k] = (g > GAIN_CAP) ? GAIN_W'(GAIN_CAP) : GAIN_W'(g);
        end
        return rom;
    endfunction

    localparam gain_rom_t GAIN_ROM = build_gain_rom();

    function automatic logic signed [SB-1:0] sat(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] hi;
        logic signed [MW-1:0] lo;
        hi = MW'((longint'(1) << (SB - 1)) - 1);
        lo = -hi - MW'(1);
        if (v > hi)
            return hi[SB-1:0];
        else if (v < lo)
            return lo[SB-1:0];
        else
            return v[SB-1:0];
    endfunction

    typedef enum logic [3:0] {
        S_IDLE, S_RES, S_FADE, S_DEC, S_RD, S_RDW, S_DIVI, S_DIV,
        S_G1, S_G2, S_G3, S_M1, S_M2, S_M3, S_MIX, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [FRAMES_W-1:0] clip_frames_reg;
    logic [RSTART_W-1:0] region_start_reg;
    logic [FRAMES_W-1:0] region_end_reg;
    logic                loop_enable_reg;
    logic [NFADE_W-1:0]  nominal_fade_reg;
    logic                mono_bus_reg;

    // captured request
    logic        [KIND_W-1:0] kind_reg;
    logic        [ADDR_W-1:0] addr_reg;
    logic signed [SB-1:0]     ld_l_reg;
    logic signed [SB-1:0]     ld_r_reg;
    logic signed [SB-1:0]     bus_l_reg;
    logic signed [SB-1:0]     bus_r_reg;

    // resolved region
    logic [CW-1:0] total_reg;
    logic [CW-1:0] start_reg;
    logic [CW-1:0] rend_reg;
    logic          valid_reg;
    logic [FW-1:0] fade_reg;

    // playback state
    logic [TW-1:0] cursor_reg;
    logic [FW-1:0] fpos_reg;
    logic [FW-1:0] ffr_reg;
    logic          active_reg;

    // crossfade datapath
    logic [FW-1:0]  ci_reg;
    logic [FW-1:0]  cf_reg;
    logic [RW-1:0]  rem_reg;
    logic [RW-1:0]  dsh_reg;
    logic [QB-1:0]  q_reg;
    logic [KW-1:0]  k_reg;
    logic [QB-1:0]  idx_reg;
    logic [GAIN_W-1:0] rom_q_reg;
    logic [GAIN_W-1:0] gin_reg;
    logic [GAIN_W-1:0] gout_reg;
    logic [ADW-1:0] rd_addr_reg;
    logic [ADW-1:0] alt_addr_reg;
    logic signed [SB-1:0]  seam_l_reg;
    logic signed [SB-1:0]  seam_r_reg;
    logic signed [SB-1:0]  strt_l_reg;
    logic signed [SB-1:0]  strt_r_reg;
    logic signed [PW-1:0]  pa_l_reg;
    logic signed [PW-1:0]  pa_r_reg;
    logic signed [PW-1:0]  pb_l_reg;
    logic signed [PW-1:0]  pb_r_reg;
    logic signed [CLW-1:0] cl_reg;
    logic signed [CLW-1:0] cr_reg;

    // result and output
    logic signed [SB-1:0] res_l_reg;
    logic signed [SB-1:0] res_r_reg;
    logic                 res_fin_reg;
    logic                 out_valid_reg;
    logic signed [SB-1:0] out_l_reg;
    logic signed [SB-1:0] out_r_reg;
    logic                 out_play_reg;
    logic                 out_fin_reg;

    // clip memories
    logic signed [SB-1:0] mem_l [CLIP_DEPTH];
    logic signed [SB-1:0] mem_r [CLIP_DEPTH];
    logic signed [SB-1:0] mem_ql_reg;
    logic signed [SB-1:0] mem_qr_reg;
    logic                 mem_oob_reg;

    logic           wr_en;
    logic           rd_en;
    logic [ADW-1:0] rd_addr;
    logic signed [SB-1:0] samp_l;
    logic signed [SB-1:0] samp_r;

    // region resolve
    logic [CW-1:0] total_c;
    logic [CW-1:0] end_c;
    logic [CW-1:0] start_c;
    logic [CW-1:0] rend_c;
    logic          valid_c;
    logic [CW-1:0] f_c;
    logic          loop_c;
    logic [CW-1:0] rend_eff;

    always_comb
    begin
        total_c = (CW'(clip_frames_reg) > CW'(CLIP_DEPTH)) ? CW'(CLIP_DEPTH)
                                                           : CW'(clip_frames_reg);
        end_c   = (region_end_reg == '0) ? total_c : CW'(region_end_reg);
        start_c = (CW'(region_start_reg) > total_c - CW'(1)) ? total_c - CW'(1)
                                                             : CW'(region_start_reg);
        rend_c  = (end_c < total_c) ? end_c : total_c;
        valid_c = (total_c != '0) && (end_c > CW'(region_start_reg)) && (rend_c > start_c);

        f_c = (nominal_fade_reg == '0) ? CW'(1) : CW'(nominal_fade_reg);
        if (total_reg - rend_reg < f_c)
            f_c = total_reg - rend_reg;
        if (total_reg - start_reg < f_c)
            f_c = total_reg - start_reg;
        if (rend_reg - start_reg < f_c)
            f_c = rend_reg - start_reg;
        if (CW'(MAX_FADE) < f_c)
            f_c = CW'(MAX_FADE);

        loop_c   = valid_reg && loop_enable_reg;
        rend_eff = valid_reg ? rend_reg : total_reg;
    end

    // memory port control
    always_comb
    begin
        wr_en = (state_reg == S_DEC) && (kind_reg == KIND_LOAD) &&
                (ADW'(addr_reg) < ADW'(CLIP_DEPTH));
        rd_en = (state_reg == S_RD) || (state_reg == S_G1) || (state_reg == S_G2);
        rd_addr = (state_reg == S_G2) ? alt_addr_reg : rd_addr_reg;
        samp_l = mem_oob_reg ? '0 : mem_ql_reg;
        samp_r = mem_oob_reg ? '0 : mem_qr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_l[AW'(addr_reg)] <= ld_l_reg;
            mem_r[AW'(addr_reg)] <= ld_r_reg;
        end
        if (rd_en)
        begin
            mem_ql_reg  <= mem_l[rd_addr[AW-1:0]];
            mem_qr_reg  <= mem_r[rd_addr[AW-1:0]];
            mem_oob_reg <= (rd_addr >= ADW'(CLIP_DEPTH));
        end
    end

    // datapath helpers
    logic [QB-1:0]        idx_c;
    logic [RW-1:0]        num_c;
    logic signed [PW+1:0] sum_l;
    logic signed [PW+1:0] sum_r;
    logic signed [MW-1:0] mix_l;
    logic signed [MW-1:0] mix_r;
    logic signed [MW-1:0] fold;
    logic [TW-1:0]        wrap_cur;

    always_comb
    begin
        idx_c = (q_reg > QB'(GAIN_TABLE_SIZE)) ? QB'(GAIN_TABLE_SIZE) : q_reg;
        num_c = RW'({ci_reg, 1'b1}) * RW'(GAIN_TABLE_SIZE) + RW'(cf_reg);
        sum_l = (PW+2)'(pa_l_reg) + (PW+2)'(pb_l_reg) + (PW+2)'(16384);
        sum_r = (PW+2)'(pa_r_reg) + (PW+2)'(pb_r_reg) + (PW+2)'(16384);
        fold  = (MW'(cl_reg) + MW'(cr_reg)) >>> 1;
        mix_l = mono_bus_reg ? MW'(bus_l_reg) + fold : MW'(bus_l_reg) + MW'(cl_reg);
        mix_r = MW'(bus_r_reg) + MW'(cr_reg);
        wrap_cur = TW'(start_reg) + TW'(fade_reg);
    end

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid     = out_valid_reg;
    assign rsp.out_left  = out_l_reg;
    assign rsp.out_right = out_r_reg;
    assign rsp.playing   = out_play_reg;
    assign rsp.finished  = out_fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            clip_frames_reg  <= '0;
            region_start_reg <= '0;
            region_end_reg   <= '0;
            loop_enable_reg  <= 1'b0;
            nominal_fade_reg <= NOMINAL_FADE_RST;
            mono_bus_reg     <= 1'b0;
            cursor_reg       <= '0;
            fpos_reg         <= '0;
            ffr_reg          <= '0;
            active_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_play_reg     <= 1'b0;
            out_fin_reg      <= 1'b0;
            out_l_reg        <= '0;
            out_r_reg        <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_CLIP_FRAMES:  clip_frames_reg  <= cfg.data;
                    CFG_REGION_START: region_start_reg <= cfg.data[RSTART_W-1:0];
                    CFG_REGION_END:   region_end_reg   <= cfg.data;
                    CFG_LOOP_ENABLE:  loop_enable_reg  <= cfg.data[0];
                    CFG_NOMINAL_FADE: nominal_fade_reg <= cfg.data[NFADE_W-1:0];
                    CFG_MONO_BUS:     mono_bus_reg     <= cfg.data[0];
                    default:          ;
                endcase
            end

            if (out_valid_reg && rsp.ready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        kind_reg  <= req.kind;
                        addr_reg  <= req.clip_address;
                        ld_l_reg  <= req.clip_left;
                        ld_r_reg  <= req.clip_right;
                        bus_l_reg <= req.bus_left;
                        bus_r_reg <= req.bus_right;
                        state_reg <= S_RES;
                    end
                end
                S_RES:
                begin
                    total_reg <= total_c;
                    start_reg <= start_c;
                    rend_reg  <= rend_c;
                    valid_reg <= valid_c;
                    state_reg <= S_FADE;
                end
                S_FADE:
                begin
                    fade_reg  <= FW'(f_c);
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    res_l_reg   <= '0;
                    res_r_reg   <= '0;
                    res_fin_reg <= 1'b0;
                    state_reg   <= S_OUT;
                    case (kind_reg)
                        KIND_LOAD: ;
                        KIND_START:
                        begin
                            if (total_reg != '0)
                            begin
                                cursor_reg <= valid_reg ? TW'(start_reg) : '0;
                                ffr_reg    <= loop_c ? fade_reg : '0;
                                fpos_reg   <= loop_c ? fade_reg : '0;
                                active_reg <= 1'b1;
                            end
                        end
                        KIND_STOP:
                            active_reg <= 1'b0;
                        default:
                        begin
                            res_l_reg <= bus_l_reg;
                            res_r_reg <= bus_r_reg;
                            if (active_reg)
                            begin
                                if (loop_c && (fpos_reg < ffr_reg))
                                begin
                                    ci_reg    <= fpos_reg;
                                    cf_reg    <= ffr_reg;
                                    fpos_reg  <= fpos_reg + FW'(1);
                                    state_reg <= S_DIVI;
                                end
                                else if (CW'(cursor_reg) >= rend_eff)
                                begin
                                    if (!loop_c)
                                    begin
                                        active_reg  <= 1'b0;
                                        res_fin_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        ffr_reg    <= fade_reg;
                                        cursor_reg <= wrap_cur;
                                        if (fade_reg != '0)
                                        begin
                                            ci_reg    <= '0;
                                            cf_reg    <= fade_reg;
                                            fpos_reg  <= FW'(1);
                                            state_reg <= S_DIVI;
                                        end
                                        else
                                        begin
                                            fpos_reg    <= '0;
                                            rd_addr_reg <= ADW'(wrap_cur);
                                            cursor_reg  <= wrap_cur + TW'(1);
                                            state_reg   <= S_RD;
                                        end
                                    end
                                end
                                else
                                begin
                                    rd_addr_reg <= ADW'(cursor_reg);
                                    cursor_reg  <= cursor_reg + TW'(1);
                                    state_reg   <= S_RD;
                                end
                            end
                        end
                    endcase
                end
                S_RD:
                    state_reg <= S_RDW;
                S_RDW:
                begin
                    cl_reg    <= CLW'(samp_l);
                    cr_reg    <= CLW'(samp_r);
                    state_reg <= S_MIX;
                end
                S_DIVI:
                begin
                    rem_reg      <= num_c;
                    dsh_reg      <= RW'(cf_reg) << QB;
                    q_reg        <= '0;
                    k_reg        <= KW'(QB - 1);
                    rd_addr_reg  <= ADW'(rend_reg) + ADW'(ci_reg);
                    alt_addr_reg <= ADW'(start_reg) + ADW'(ci_reg);
                    state_reg    <= S_DIV;
                end
                S_DIV:
                begin
                    if (rem_reg >= dsh_reg)
                    begin
                        rem_reg <= rem_reg - dsh_reg;
                        q_reg   <= {q_reg[QB-2:0], 1'b1};
                    end
                    else
                        q_reg <= {q_reg[QB-2:0], 1'b0};
                    dsh_reg <= dsh_reg >> 1;
                    if (k_reg == '0)
                        state_reg <= S_G1;
                    else
                        k_reg <= k_reg - KW'(1);
                end
                S_G1:
                begin
                    idx_reg   <= idx_c;
                    rom_q_reg <= GAIN_ROM[idx_c];
                    state_reg <= S_G2;
                end
                S_G2:
                begin
                    gin_reg    <= rom_q_reg;
                    rom_q_reg  <= GAIN_ROM[QB'(GAIN_TABLE_SIZE) - idx_reg];
                    seam_l_reg <= samp_l;
                    seam_r_reg <= samp_r;
                    state_reg  <= S_G3;
                end
                S_G3:
                begin
                    gout_reg   <= rom_q_reg;
                    strt_l_reg <= samp_l;
                    strt_r_reg <= samp_r;
                    state_reg  <= S_M1;
                end
                S_M1:
                begin
                    pa_l_reg  <= PW'(seam_l_reg) * $signed({1'b0, gout_reg});
                    pa_r_reg  <= PW'(seam_r_reg) * $signed({1'b0, gout_reg});
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    pb_l_reg  <= PW'(strt_l_reg) * $signed({1'b0, gin_reg});
                    pb_r_reg  <= PW'(strt_r_reg) * $signed({1'b0, gin_reg});
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    cl_reg    <= CLW'(sum_l >>> 15);
                    cr_reg    <= CLW'(sum_r >>> 15);
                    state_reg <= S_MIX;
                end
                S_MIX:
                begin
                    res_l_reg <= sat(mix_l);
                    if (!mono_bus_reg)
                        res_r_reg <= sat(mix_r);
                    if (!loop_c && (CW'(cursor_reg) >= rend_eff))
                    begin
                        active_reg  <= 1'b0;
                        res_fin_reg <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_l_reg     <= res_l_reg;
                        out_r_reg     <= res_r_reg;
                        out_play_reg  <= active_reg;
                        out_fin_reg   <= res_fin_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* design/lcp_checker.sv */
// ----------------------------------------------------------------------------
// lcp_checker
// port-level assertions on the clip player, bound to the top level
// ----------------------------------------------------------------------------
`include "loop_clip_player_crossfade_top_macros.svh"

module lcp_checker
    import lcp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic [SAMPLE_BITS-1:0] rsp_out_left,
    input logic [SAMPLE_BITS-1:0] rsp_out_right,
    input logic                   rsp_playing,
    input logic                   rsp_finished
);

    `LCP_ASSERT_IMP(a_fin_stops, rsp_valid && rsp_finished, !rsp_playing, "finished while playing")
    `LCP_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while busy")
    `LCP_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_left) && $stable(rsp_out_right), "stalled response changed")
    `LCP_ASSERT_IMP(a_rsp_drop, $fell(rsp_valid), $past(rsp_ready), "response dropped")

endmodule

bind loop_clip_player_crossfade_top lcp_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lcp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_out_left  (rsp.out_left),
    .rsp_out_right (rsp.out_right),
    .rsp_playing   (rsp.playing),
    .rsp_finished  (rsp.finished)
);
